>>> hdl/dstab_pkg.sv
// ---------------------------------------------------------------------------
// dstab_pkg
// Shared types and codes for the date-sorted record table.
// ---------------------------------------------------------------------------
package dstab_pkg;

   localparam int CodeW = 64;
   localparam int DateW = 23;
   localparam int TagW  = 32;

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_FIND    = 3'd1;
   localparam logic [2:0] CMD_DEL_KEY = 3'd2;
   localparam logic [2:0] CMD_DEL_RNG = 3'd3;
   localparam logic [2:0] CMD_DUMP    = 3'd4;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_REC  = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [CodeW-1:0] code;
      logic [DateW-1:0] date;
      logic [TagW-1:0]  tag;
   } rec_type;

   typedef struct packed {
      logic ge_lo;
      logic le_hi;
      logic code_eq;
   } cmp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINISH
   } state_type;

endpackage

>>> hdl/dstab_mem.sv
// ---------------------------------------------------------------------------
// dstab_mem
// Record storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dstab_mem
   import dstab_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output rec_type       rd_data
);

   rec_type mem_ff [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dstab_cmp.sv
// ---------------------------------------------------------------------------
// dstab_cmp
// Shared compare unit: date bounds and code match for one entry.
// ---------------------------------------------------------------------------
module dstab_cmp
   import dstab_pkg::*;
(
   input  rec_type          entry,
   input  logic [DateW-1:0] lo,
   input  logic [DateW-1:0] hi,
   input  logic [CodeW-1:0] code,
   output cmp_type          result
);

   assign result.ge_lo   = entry.date >= lo;
   assign result.le_hi   = entry.date <= hi;
   assign result.code_eq = entry.code == code;

endmodule

>>> hdl/date_sorted_record_table.sv
// ---------------------------------------------------------------------------
// date_sorted_record_table
// Date-ordered record table with insert, find, delete and dump commands.
// ---------------------------------------------------------------------------
// Each command walks the table one entry at a time through a record memory
// with one write port, one read port and registered read data, and one
// shared compare unit; the walk waits while the result side stalls. Insert
// into a full table and unused command codes skip the walk. Inserts and
// deletes move entries in the same pass, so no extra cycles are spent on
// shifting.
// req_ready is high only while no command is in progress.
// ---------------------------------------------------------------------------
module date_sorted_record_table
   import dstab_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int CODE_CHARS  = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_command,
   input  logic [63:0]  req_key_code,
   input  logic [13:0]  req_year,
   input  logic [3:0]   req_month,
   input  logic [4:0]   req_day,
   input  logic [31:0]  req_payload,
   input  logic [13:0]  req_year_hi,
   input  logic [3:0]   req_month_hi,
   input  logic [4:0]   req_day_hi,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status,
   output logic [63:0]  rsp_out_code,
   output logic [13:0]  rsp_out_year,
   output logic [3:0]   rsp_out_month,
   output logic [4:0]   rsp_out_day,
   output logic [31:0]  rsp_out_payload,
   output logic         rsp_last
);

   localparam int CountW = $clog2(TABLE_DEPTH + 1);
   localparam int IdxW   = $clog2(TABLE_DEPTH);
   localparam logic [CodeW-1:0] CodeMask = (CODE_CHARS >= 8) ? {CodeW{1'b1}} :
      ((CodeW'(1) << (8 * CODE_CHARS)) - CodeW'(1));
   localparam logic [CountW-1:0] Full = CountW'(TABLE_DEPTH);

   state_type         state_ff, state_in;
   logic [2:0]        cmd_ff, cmd_in;
   logic [CodeW-1:0]  code_ff, code_in;
   logic [DateW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [TagW-1:0]   tag_ff, tag_in;
   logic [CountW-1:0] r_ff, r_in, w_ff, w_in, fill_ff, fill_in;
   logic              full_ff, full_in;
   logic              ins_ff, ins_in;
   rec_type           carry_ff, carry_in;
   rec_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   rec_type           out_ff, out_in;
   logic              last_ff, last_in;

   logic              wr_en, rd_en;
   logic [IdxW-1:0]   wr_addr;
   rec_type           wr_data, rd_data, new_rec;
   cmp_type           cmp;
   logic              can_emit, hit, remove;
   logic [DateW-1:0]  req_lo, req_hi;

   dstab_mem #(.DEPTH(TABLE_DEPTH), .AW(IdxW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (r_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   dstab_cmp u_cmp (
      .entry  (rd_data),
      .lo     (lo_ff),
      .hi     (hi_ff),
      .code   (code_ff),
      .result (cmp)
   );

   assign req_lo   = {req_year, req_month, req_day};
   assign req_hi   = {req_year_hi, req_month_hi, req_day_hi};
   assign new_rec  = '{code: code_ff, date: lo_ff, tag: tag_ff};
   assign can_emit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd_ff)
         CMD_DUMP:    hit = 1'b1;
         CMD_DEL_RNG: hit = cmp.ge_lo && cmp.le_hi;
         default:     hit = cmp.code_eq && !pend_valid_ff;
      endcase
      remove = hit && (cmd_ff == CMD_DEL_KEY || cmd_ff == CMD_DEL_RNG);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      code_in       = code_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      tag_in        = tag_ff;
      r_in          = r_ff;
      w_in          = w_ff;
      fill_in       = fill_ff;
      full_in       = full_ff;
      ins_in        = ins_ff;
      carry_in      = carry_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      status_in     = status_ff;
      out_in        = out_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_addr       = r_ff[IdxW-1:0];
      wr_data       = new_rec;
      rd_en         = 1'b0;
      req_ready     = state_ff == S_IDLE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               code_in       = req_key_code & CodeMask;
               tag_in        = req_payload;
               lo_in         = req_lo;
               hi_in         = req_hi;
               if (req_command == CMD_DEL_RNG && req_lo > req_hi) begin
                  lo_in = req_hi;
                  hi_in = req_lo;
               end
               r_in          = '0;
               w_in          = '0;
               ins_in        = 1'b0;
               pend_valid_in = 1'b0;
               full_in       = req_command == CMD_INSERT && fill_ff == Full;
               if (req_command > CMD_DUMP || full_in) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            if (r_ff == fill_ff) begin
               if (cmd_ff == CMD_INSERT) begin
                  wr_en   = 1'b1;
                  wr_data = ins_ff ? carry_ff : new_rec;
                  fill_in = fill_ff + CountW'(1);
               end else begin
                  fill_in = w_ff;
               end
               state_in = S_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (cmd_ff == CMD_INSERT) begin
               if (ins_ff || cmp.ge_lo) begin
                  wr_en    = 1'b1;
                  wr_data  = ins_ff ? carry_ff : new_rec;
                  carry_in = rd_data;
                  ins_in   = 1'b1;
               end
               r_in     = r_ff + CountW'(1);
               state_in = S_READ;
            end else if (!(hit && pend_valid_ff && !can_emit)) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ST_REC;
                     out_in       = pend_ff;
                     last_in      = 1'b0;
                  end
                  pend_in       = rd_data;
                  pend_valid_in = 1'b1;
               end
               if (!remove) begin
                  wr_en   = 1'b1;
                  wr_addr = w_ff[IdxW-1:0];
                  wr_data = rd_data;
                  w_in    = w_ff + CountW'(1);
               end
               r_in     = r_ff + CountW'(1);
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               out_in       = '0;
               if (cmd_ff == CMD_INSERT) begin
                  status_in = full_ff ? ST_FULL : ST_DONE;
               end else if (pend_valid_ff) begin
                  status_in = ST_REC;
                  out_in    = pend_ff;
               end else begin
                  status_in = ST_NONE;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         ins_ff        <= 1'b0;
         full_ff       <= 1'b0;
         r_ff          <= '0;
         w_ff          <= '0;
         cmd_ff        <= CMD_INSERT;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         ins_ff        <= ins_in;
         full_ff       <= full_in;
         r_ff          <= r_in;
         w_ff          <= w_in;
         cmd_ff        <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      tag_ff    <= tag_in;
      carry_ff  <= carry_in;
      pend_ff   <= pend_in;
      status_ff <= status_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_code    = out_ff.code;
   assign rsp_out_year    = out_ff.date[22:9];
   assign rsp_out_month   = out_ff.date[8:5];
   assign rsp_out_day     = out_ff.date[4:0];
   assign rsp_out_payload = out_ff.tag;
   assign rsp_last        = last_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= Full) else $error("fill count beyond table depth");

   a_write_behind_read : assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> w_ff <= r_ff) else $error("write index ahead of read");

   a_single_final : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_REC |-> last_ff)
      else $error("non-record result without last");

endmodule

>>> tb/date_sorted_record_table_tb.sv
// ---------------------------------------------------------------------------
// date_sorted_record_table_tb
// Self-checking bench for the date-sorted record table. A directed table of
// commands covers the empty table, date and code extremes, reversed range
// bounds, duplicates and unused codes. A full table follows, then weighted
// random commands. Every result transfer is checked against a behavioral
// copy of the table, with random stalls on both channels.
// ---------------------------------------------------------------------------
module date_sorted_record_table_tb;
   import dstab_pkg::*;

   localparam int         Depth      = 32;
   localparam int         Latency    = 2 * Depth + 10;
   localparam int         CycleLimit = 600000;
   localparam int         NumRandom  = 300;
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] code;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [31:0] payload;
      logic        last;
   } answer_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [63:0] code;
      logic [13:0] y;
      logic [3:0]  m;
      logic [4:0]  d;
      logic [31:0] pay;
      logic [13:0] yh;
      logic [3:0]  mh;
      logic [4:0]  dh;
      bit          typed;
      logic [1:0]  status;
   } command_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_command = 0;
   logic [63:0] req_key_code = 0;
   logic [13:0] req_year = 0;
   logic [3:0]  req_month = 0;
   logic [4:0]  req_day = 0;
   logic [31:0] req_payload = 0;
   logic [13:0] req_year_hi = 0;
   logic [3:0]  req_month_hi = 0;
   logic [4:0]  req_day_hi = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_out_code;
   logic [13:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [31:0] rsp_out_payload;
   logic        rsp_last;

   logic [63:0] table_code [Depth];
   logic [22:0] table_date [Depth];
   logic [31:0] table_tag [Depth];
   int          table_fill = 0;
   answer_type  answer_q [$];
   command_type directed [$];
   int          errors = 0;
   int          cycles = 0;
   int          stall_cnt = 0;
   bit          hold_pending = 0;
   bit          quiet = 0;
   logic [63:0] code_pool [8];

   date_sorted_record_table dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout at %0t", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= 0;
      end else if (hold_pending) begin
         hold_pending <= 0;
         stall_cnt <= 250;
         rsp_ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_cnt <= $urandom_range(0, 2);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   task automatic push_answer(logic [1:0] st, int idx, logic fin);
      answer_type a;
      a = '{st, 0, 0, 0, 0, 0, fin};
      if (idx >= 0) begin
         a.code = table_code[idx];
         {a.year, a.month, a.day} = table_date[idx];
         a.payload = table_tag[idx];
      end
      answer_q.push_back(a);
   endtask

   task automatic drop_entry(int idx);
      for (int i = idx; i + 1 < table_fill; i++) begin
         table_code[i] = table_code[i + 1];
         table_date[i] = table_date[i + 1];
         table_tag[i] = table_tag[i + 1];
      end
      table_fill--;
   endtask

   function automatic int first_code(logic [63:0] code);
      for (int i = 0; i < table_fill; i++)
         if (table_code[i] == code) return i;
      return -1;
   endfunction

   task automatic predict_table(command_type c);
      logic [22:0] lo, hi, t;
      int          pos, hits;
      lo = {c.y, c.m, c.d};
      hi = {c.yh, c.mh, c.dh};
      hits = 0;
      case (c.cmd)
         CMD_INSERT: begin
            if (table_fill >= Depth) begin
               push_answer(ST_FULL, -1, 1);
            end else begin
               pos = 0;
               while (pos < table_fill && table_date[pos] < lo) pos++;
               for (int j = table_fill; j > pos; j--) begin
                  table_code[j] = table_code[j - 1];
                  table_date[j] = table_date[j - 1];
                  table_tag[j] = table_tag[j - 1];
               end
               table_code[pos] = c.code;
               table_date[pos] = lo;
               table_tag[pos] = c.pay;
               table_fill++;
               push_answer(ST_DONE, -1, 1);
            end
         end
         CMD_FIND, CMD_DEL_KEY: begin
            pos = first_code(c.code);
            push_answer(pos >= 0 ? ST_REC : ST_NONE, pos, 1);
            if (pos >= 0 && c.cmd == CMD_DEL_KEY) drop_entry(pos);
         end
         CMD_DEL_RNG: begin
            if (lo > hi) begin
               t = lo;
               lo = hi;
               hi = t;
            end
            pos = 0;
            while (pos < table_fill) begin
               if (table_date[pos] >= lo && table_date[pos] <= hi) begin
                  push_answer(ST_REC, pos, 0);
                  hits++;
                  drop_entry(pos);
               end else begin
                  pos++;
               end
            end
            if (hits == 0) push_answer(ST_NONE, -1, 1);
            else answer_q[$].last = 1;
         end
         CMD_DUMP: begin
            if (table_fill == 0) push_answer(ST_NONE, -1, 1);
            for (int i = 0; i < table_fill; i++) push_answer(ST_REC, i, i + 1 == table_fill);
         end
         default: push_answer(ST_NONE, -1, 1);
      endcase
   endtask

   function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
         errors++;
      end
   endfunction

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            check_field("status", answer_q[0].status, rsp_status);
            check_field("code", answer_q[0].code, rsp_out_code);
            check_field("year", answer_q[0].year, rsp_out_year);
            check_field("month", answer_q[0].month, rsp_out_month);
            check_field("day", answer_q[0].day, rsp_out_day);
            check_field("payload", answer_q[0].payload, rsp_out_payload);
            check_field("last", answer_q[0].last, rsp_last);
            void'(answer_q.pop_front());
         end
      end
   end

   task automatic send_command(command_type c);
      int gap, base;
      gap = quiet ? 0 : ($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= c.cmd;
      req_key_code <= c.code;
      req_year <= c.y;
      req_month <= c.m;
      req_day <= c.d;
      req_payload <= c.pay;
      req_year_hi <= c.yh;
      req_month_hi <= c.mh;
      req_day_hi <= c.dh;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      base = answer_q.size();
      predict_table(c);
      if (c.typed && answer_q[base].status !== c.status) begin
         $display("%0t mismatch typed status: expected %0d actual %0d",
                  $time, c.status, answer_q[base].status);
         errors++;
      end
   endtask

   function automatic command_type mk(logic [2:0] cmd, logic [63:0] code, logic [13:0] y,
                                      logic [3:0] m, logic [4:0] d, logic [31:0] pay,
                                      logic [13:0] yh, logic [3:0] mh, logic [4:0] dh,
                                      bit typed, logic [1:0] st);
      command_type c;
      c = '{cmd, code, y, m, d, pay, yh, mh, dh, typed, st};
      return c;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int          pick;
      pick = $urandom_range(0, 99);
      c.cmd = pick < 42 ? CMD_INSERT : pick < 57 ? CMD_FIND : pick < 72 ? CMD_DEL_KEY :
              pick < 84 ? CMD_DEL_RNG : pick < 95 ? CMD_DUMP : 3'($urandom_range(5, 7));
      c.code = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : code_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 4) == 0) begin
         {c.y, c.m, c.d} = 23'($urandom);
         {c.yh, c.mh, c.dh} = 23'($urandom);
      end else begin
         c.y = 14'(2000 + $urandom_range(0, 5));
         c.m = 4'($urandom_range(1, 12));
         c.d = 5'($urandom_range(1, 31));
         c.yh = 14'(2000 + $urandom_range(0, 5));
         c.mh = 4'($urandom_range(1, 12));
         c.dh = 5'($urandom_range(1, 31));
      end
      c.pay = $urandom;
      c.typed = 0;
      c.status = ST_DONE;
      return c;
   endfunction

   initial begin
      command_type c;
      for (int i = 0; i < 8; i++) code_pool[i] = {$urandom, $urandom};
      directed.push_back(mk(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      directed.push_back(mk(CMD_FIND, '1, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      directed.push_back(mk(CMD_DEL_KEY, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      directed.push_back(mk(CMD_DEL_RNG, 0, 0, 0, 0, 0, '1, '1, '1, 1, ST_NONE));
      directed.push_back(mk(CMD_SPARE5, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      directed.push_back(mk(CMD_SPARE7, '1, '1, '1, '1, '1, '1, '1, '1, 1, ST_NONE));
      directed.push_back(mk(CMD_INSERT, '1, 9999, 12, 31, '1, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_INSERT, 64'h4142, '1, '1, '1, 32'h55, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_INSERT, 64'h4142, 2020, 5, 5, 32'h1, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_INSERT, 64'h4142, 2020, 5, 5, 32'h2, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_INSERT, 64'h4343, 2020, 5, 5, 32'h3, 0, 0, 0, 1, ST_DONE));
      directed.push_back(mk(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_REC));
      directed.push_back(mk(CMD_FIND, 64'h4142, 0, 0, 0, 0, 0, 0, 0, 0, ST_REC));
      directed.push_back(mk(CMD_FIND, '1, 0, 0, 0, 0, 0, 0, 0, 0, ST_REC));
      directed.push_back(mk(CMD_DEL_KEY, 64'h4142, 0, 0, 0, 0, 0, 0, 0, 0, ST_REC));
      directed.push_back(mk(CMD_DEL_KEY, 64'h9999, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE));
      directed.push_back(mk(CMD_DEL_RNG, 0, 2020, 5, 5, 0, 2000, 1, 1, 0, ST_REC));
      directed.push_back(mk(CMD_DEL_RNG, 0, 2020, 5, 6, 0, 2020, 5, 6, 1, ST_NONE));
      directed.push_back(mk(CMD_DUMP, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_REC));
      directed.push_back(mk(CMD_DEL_RNG, 0, '1, '1, '1, 0, 0, 0, 0, 0, ST_REC));

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_command(directed[i]);

      while (table_fill < Depth) begin
         c = random_command();
         c.cmd = CMD_INSERT;
         send_command(c);
      end
      c = random_command();
      c.cmd = CMD_INSERT;
      c.typed = 1;
      c.status = ST_FULL;
      send_command(c);
      c.cmd = CMD_DUMP;
      c.typed = 0;
      send_command(c);

      for (int n = 0; n < NumRandom; n++) begin
         if (n == 60) hold_pending = 1;
         if (n == 150) begin
            req_valid <= 0;
            wait (answer_q.size() == 0);
            repeat (Latency) @(posedge clock);
         end
         if (n == 250) quiet = 1;
         send_command(random_command());
      end
      req_valid <= 0;
      wait (answer_q.size() == 0);
      repeat (Latency) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
